[src/lad_pkg.sv]
// ----------------------------------------------------------------------------
// lad_pkg
// Shared types and constants for the lock actuator dwell controller.
// ----------------------------------------------------------------------------
package lad_pkg;

  localparam int unsigned CountW = 7;
  localparam int unsigned LimitW = 6;

  localparam logic [CountW-1:0] CountMax       = 7'd127;
  localparam logic [LimitW-1:0] FailLimitReset = 6'd10;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_SCHED  = 2'd1,
    MODE_MANUAL = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_UNKNOWN     = 3'd0,
    ST_LOCKED      = 3'd1,
    ST_UNLOCKED    = 3'd2,
    ST_FAIL_LOCK   = 3'd3,
    ST_FAIL_UNLOCK = 3'd4
  } status_e;

  typedef struct packed {
    logic              armed;
    logic              drive;
    logic [CountW-1:0] count;
    logic              hit_ok;
    logic              hit_fail;
  } dwell_res_t;

endpackage

[src/lock_actuator_dwell_controller_core.sv]
// ----------------------------------------------------------------------------
// lock_actuator_dwell_controller_core
// Lock actuator drive with dwell waits on active-low limit switches.
//
// Input channel (in_valid_i / in_stall_o): one beat is a tick or a lock or
// unlock command with the raw switch levels. Output channel (out_valid_o /
// out_stall_i): one beat per input beat with both drives, status and busy.
// Config channel (cfg_valid_i / cfg_ready_o): writes fail_limit; write it
// only while no beat is in flight.
// An input register, then one pass of update logic into the result register
// and the controller state. One beat per cycle is accepted while the
// receiver does not stall.
// When the receiver stalls, the result register holds; the input register
// still takes one more beat, then in_stall_o rises until the result drains.
// Reset clears drives, waits, counts and status (unknown), sets fail_limit
// to 10 and empties both registers.
// ----------------------------------------------------------------------------
module lock_actuator_dwell_controller_core
  import lad_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic              want_locked_i,
  input  logic              locked_switch_open_i,
  input  logic              unlocked_switch_open_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              lock_drive_o,
  output logic              unlock_drive_o,
  output logic [2:0]        status_o,
  output logic              busy_res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [LimitW-1:0] cfg_data_i
);

  logic              in_vld_q;
  logic [1:0]        mode_q;
  logic              want_q, lk_open_q, ul_open_q;
  logic [LimitW-1:0] fail_limit_q;

  logic              lk_armed_q, lk_armed_d, ul_armed_q, ul_armed_d;
  logic              lk_drive_q, lk_drive_d, ul_drive_q, ul_drive_d;
  logic [CountW-1:0] lk_cnt_q, lk_cnt_d, ul_cnt_q, ul_cnt_d;
  status_e           status_q, status_d;

  logic              out_vld_q;
  logic              out_lk_q, out_ul_q, out_busy_q;
  logic [2:0]        out_status_q;

  logic              advance;
  dwell_res_t        lk_res, ul_res;

  assign advance     = in_vld_q && !(out_vld_q && out_stall_i);
  assign in_stall_o  = in_vld_q && out_vld_q && out_stall_i;
  assign cfg_ready_o = 1'b1;

  lad_dwell u_lk_dwell (
    .armed_i      (lk_armed_q),
    .drive_i      (lk_drive_q),
    .count_i      (lk_cnt_q),
    .sw_open_i    (lk_open_q),
    .fail_limit_i (fail_limit_q),
    .res_o        (lk_res)
  );

  lad_dwell u_ul_dwell (
    .armed_i      (ul_armed_q),
    .drive_i      (ul_drive_q),
    .count_i      (ul_cnt_q),
    .sw_open_i    (ul_open_q),
    .fail_limit_i (fail_limit_q),
    .res_o        (ul_res)
  );

  always_comb begin
    lk_armed_d = lk_armed_q;
    ul_armed_d = ul_armed_q;
    lk_drive_d = lk_drive_q;
    ul_drive_d = ul_drive_q;
    lk_cnt_d   = lk_cnt_q;
    ul_cnt_d   = ul_cnt_q;
    status_d   = status_q;
    case (mode_q)
      MODE_TICK: begin
        lk_armed_d = lk_res.armed;
        lk_drive_d = lk_res.drive;
        lk_cnt_d   = lk_res.count;
        ul_armed_d = ul_res.armed;
        ul_drive_d = ul_res.drive;
        ul_cnt_d   = ul_res.count;
        if (lk_res.hit_fail) begin
          status_d = ST_FAIL_LOCK;
        end else if (lk_res.hit_ok) begin
          status_d = ST_LOCKED;
        end
        if (ul_res.hit_fail) begin
          status_d = ST_FAIL_UNLOCK;
        end else if (ul_res.hit_ok) begin
          status_d = ST_UNLOCKED;
        end
      end
      MODE_SCHED, MODE_MANUAL: begin
        if (want_q) begin
          if (lk_open_q) begin
            ul_armed_d = 1'b0;
            lk_drive_d = 1'b1;
            ul_drive_d = 1'b0;
            lk_armed_d = 1'b1;
          end else if (mode_q == MODE_MANUAL) begin
            status_d = ST_LOCKED;
          end
        end else begin
          if (ul_open_q) begin
            lk_armed_d = 1'b0;
            lk_drive_d = 1'b0;
            ul_drive_d = 1'b1;
            ul_armed_d = 1'b1;
          end else if (mode_q == MODE_MANUAL) begin
            status_d = ST_UNLOCKED;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      fail_limit_q <= FailLimitReset;
      lk_armed_q   <= 1'b0;
      ul_armed_q   <= 1'b0;
      lk_drive_q   <= 1'b0;
      ul_drive_q   <= 1'b0;
      lk_cnt_q     <= '0;
      ul_cnt_q     <= '0;
      status_q     <= ST_UNKNOWN;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        fail_limit_q <= cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q  <= 1'b1;
        lk_armed_q <= lk_armed_d;
        ul_armed_q <= ul_armed_d;
        lk_drive_q <= lk_drive_d;
        ul_drive_q <= ul_drive_d;
        lk_cnt_q   <= lk_cnt_d;
        ul_cnt_q   <= ul_cnt_d;
        status_q   <= status_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      mode_q    <= mode_i;
      want_q    <= want_locked_i;
      lk_open_q <= locked_switch_open_i;
      ul_open_q <= unlocked_switch_open_i;
    end
    if (advance) begin
      out_lk_q     <= lk_drive_d;
      out_ul_q     <= ul_drive_d;
      out_status_q <= status_d;
      out_busy_q   <= lk_armed_d | ul_armed_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign lock_drive_o   = out_lk_q;
  assign unlock_drive_o = out_ul_q;
  assign status_o       = out_status_q;
  assign busy_res_o     = out_busy_q;

  a_drive_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lk_drive_q && ul_drive_q))
    else $error("both drives energized");

  a_lk_armed_drives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lk_armed_q |-> lk_drive_q)
    else $error("lock wait armed without lock drive");

  a_ul_armed_drives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ul_armed_q |-> ul_drive_q)
    else $error("unlock wait armed without unlock drive");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lk_cnt_q <= CountW'(63)) && (ul_cnt_q <= CountW'(63)))
    else $error("dwell count beyond limit range");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q))
    else $error("input stalled with free pipeline");

endmodule

[src/lad_dwell.sv]
// ----------------------------------------------------------------------------
// lad_dwell
// Tick update of one direction's dwell wait: count, success or failure.
// ----------------------------------------------------------------------------
module lad_dwell
  import lad_pkg::*;
(
  input  logic              armed_i,
  input  logic              drive_i,
  input  logic [CountW-1:0] count_i,
  input  logic              sw_open_i,
  input  logic [LimitW-1:0] fail_limit_i,
  output dwell_res_t        res_o
);

  logic [CountW-1:0] cnt_step;

  always_comb begin
    cnt_step = count_i;
    res_o    = '{armed: armed_i, drive: drive_i, count: count_i,
                 hit_ok: 1'b0, hit_fail: 1'b0};
    if (armed_i) begin
      if (sw_open_i) begin
        if (count_i < CountMax) begin
          cnt_step = count_i + CountW'(1);
        end
        res_o.count = cnt_step;
      end else begin
        cnt_step     = '0;
        res_o.count  = '0;
        res_o.drive  = 1'b0;
        res_o.armed  = 1'b0;
        res_o.hit_ok = 1'b1;
      end
      if (cnt_step > {1'b0, fail_limit_i}) begin
        res_o.count    = '0;
        res_o.drive    = 1'b0;
        res_o.armed    = 1'b0;
        res_o.hit_ok   = 1'b0;
        res_o.hit_fail = 1'b1;
      end
    end
  end

endmodule
